// ----- design/f2c_pkg.sv -----
// Shared types, codes and constants of the Frenet-to-Cartesian converter.
package f2c_pkg;

  localparam int MAX_POINTS_DEF = 256;

  localparam int COORD_W   = 32;
  localparam int ENTRY_W   = 4 * COORD_W;
  localparam int IN_DATA_W = 6 * COORD_W;
  localparam int OUT_DATA_W = 3 * COORD_W;
  localparam int CORDIC_STEPS = 24;
  localparam int TRIG_W    = 34;
  localparam int MUL_W     = 34;

  localparam logic signed [32:0] WRAP_LIMIT  = 33'sd105357149;
  localparam logic        [31:0] TWO_PI_Q24  = 32'd105414357;
  localparam logic signed [32:0] TWO_PI_S    = 33'sd105414357;
  localparam logic signed [32:0] PI_Q24      = 33'sd52707179;
  localparam logic signed [32:0] HALF_PI_Q24 = 33'sd26353589;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_INTERP = 3'd1,
    STAT_CLAMP  = 3'd2,
    STAT_BEFORE = 3'd3,
    STAT_FEW    = 3'd4,
    STAT_FULL   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_SCAN,
    S_DIV,
    S_LERP,
    S_RLOAD,
    S_REDUCE,
    S_FOLD,
    S_CORDIC,
    S_OFFS
  } state_t;

  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd13176795;
      5'd1:  v = 32'sd7778716;
      5'd2:  v = 32'sd4110060;
      5'd3:  v = 32'sd2086331;
      5'd4:  v = 32'sd1047214;
      5'd5:  v = 32'sd524117;
      5'd6:  v = 32'sd262123;
      5'd7:  v = 32'sd131069;
      5'd8:  v = 32'sd65536;
      5'd9:  v = 32'sd32768;
      5'd10: v = 32'sd16384;
      5'd11: v = 32'sd8192;
      5'd12: v = 32'sd4096;
      5'd13: v = 32'sd2048;
      5'd14: v = 32'sd1024;
      5'd15: v = 32'sd512;
      5'd16: v = 32'sd256;
      5'd17: v = 32'sd128;
      5'd18: v = 32'sd64;
      5'd19: v = 32'sd32;
      5'd20: v = 32'sd16;
      5'd21: v = 32'sd8;
      5'd22: v = 32'sd4;
      5'd23: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) r = 32'sh7fffffff;
    else if (v < -39'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- design/f2c_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module f2c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/frenet_to_cartesian_unit.sv -----
// Top level of the Frenet-to-Cartesian converter: path store, scan, divide, CORDIC, offset.
//
// Clear, append and unused-op transfers, and queries on a path of fewer than two points,
// present their result the cycle after the input transfer. A query reads the path memory
// one entry a cycle from the start until the first matching segment or the last point. A
// query inside the path then passes through the bit-serial divider, the shared multiplier
// for interpolation, heading range reduction by repeated subtraction, the CORDIC unit and
// the shared multiplier for the lateral offset; a query beyond the last point skips the
// divider and the interpolation, and one before the first point ends after the scan. The
// block takes one item at a time and accepts the next once its result has been transferred.
// The path memory needs no clearing after reset.
module frenet_to_cartesian_unit
  import f2c_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // point_s, point_x, point_y, point_heading, query_s, query_l
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x, out_y, out_heading
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [2:0]            m_tuser
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] k;
  logic [4:0]        cnt;

  logic we;
  logic [ADDR_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;

  logic signed [31:0] q, l;
  logic signed [31:0] s0, x0, y0, h0, x1, y1, h1;
  logic signed [31:0] px, py, ph;
  logic [32:0] rem, span;
  logic [30:0] quo;
  logic [31:0] mag;
  logic        hneg, neg;
  logic signed [TRIG_W-1:0] cx, cy;
  logic signed [31:0] cz;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  logic signed [31:0] rd_s, rd_x, rd_y, rd_h;
  logic [CNT_W-1:0]   last;
  logic               hit, at_last, beyond;
  op_t                in_op;

  assign in_op = op_t'(s_tuser);
  assign rd_s = rdata[31:0];
  assign rd_x = rdata[63:32];
  assign rd_y = rdata[95:64];
  assign rd_h = rdata[127:96];
  assign last = count - CNT_W'(1);
  assign hit = (q >= s0) && (q < rd_s);
  assign at_last = (k == last[ADDR_W-1:0]);
  assign beyond = (q >= rd_s);
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  f2c_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_path (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({s_tdata[127:96], s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready && in_op == OP_QUERY && count >= CNT_W'(2)) begin
          state_next = S_RD0;
        end
      end
      S_RD0: state_next = S_RD1;
      S_RD1: state_next = S_SCAN;
      S_SCAN: begin
        if (hit) state_next = S_DIV;
        else if (at_last) state_next = beyond ? S_RLOAD : S_IDLE;
      end
      S_DIV: if (cnt == 5'd30) state_next = S_LERP;
      S_LERP: if (cnt == 5'd5) state_next = S_RLOAD;
      S_RLOAD: state_next = S_REDUCE;
      S_REDUCE: if (mag < TWO_PI_Q24) state_next = S_FOLD;
      S_FOLD: state_next = S_CORDIC;
      S_CORDIC: if (cnt == 5'(CORDIC_STEPS - 1)) state_next = S_OFFS;
      S_OFFS: if (cnt == 5'd3) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and multiplier operands
  always_comb begin
    we = 1'b0;
    raddr = k + ADDR_W'(1);
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IDLE: begin
        we = s_tvalid && s_tready && in_op == OP_APPEND && count < CNT_W'(MAX_POINTS);
      end
      S_RD0: raddr = '0;
      S_RD1: raddr = ADDR_W'(1);
      S_LERP: begin
        logic signed [32:0] d;
        case (cnt[2:1])
          2'd0: d = 33'(x1) - 33'(x0);
          2'd1: d = 33'(y1) - 33'(y0);
          default: d = 33'(h1) - 33'(h0);
        endcase
        mul_a = d[32] ? MUL_W'(-d) : MUL_W'(d);
        mul_a[MUL_W-1] = 1'b0;
        mul_b = MUL_W'({1'b0, quo});
      end
      S_OFFS: begin
        mul_a = cnt[1] ? (neg ? -cx : cx) : (neg ? -cy : cy);
        mul_b = MUL_W'(l);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      k <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            q <= s_tdata[159:128];
            l <= s_tdata[191:160];
            m_tdata <= '0;
            case (in_op)
              OP_CLEAR: begin
                count <= '0;
                m_tuser <= STAT_OK;
                m_tvalid <= 1'b1;
              end
              OP_APPEND: begin
                m_tvalid <= 1'b1;
                if (count < CNT_W'(MAX_POINTS)) begin
                  count <= count + CNT_W'(1);
                  m_tuser <= STAT_OK;
                end else begin
                  m_tuser <= STAT_FULL;
                end
              end
              OP_QUERY: begin
                m_tuser <= (count < CNT_W'(2)) ? STAT_FEW : STAT_OK;
                m_tvalid <= (count < CNT_W'(2));
              end
              default: begin
                m_tuser <= STAT_OK;
                m_tvalid <= 1'b1;
              end
            endcase
          end
        end
        S_RD1: begin
          s0 <= rd_s; x0 <= rd_x; y0 <= rd_y; h0 <= rd_h;
          k <= ADDR_W'(1);
        end
        S_SCAN: begin
          if (hit) begin
            x1 <= rd_x; y1 <= rd_y; h1 <= rd_h;
            rem <= 33'(q) - 33'(s0);
            span <= 33'(rd_s) - 33'(s0);
            quo <= '0;
            cnt <= '0;
          end else if (at_last) begin
            if (beyond) begin
              px <= rd_x; py <= rd_y; ph <= rd_h;
              m_tuser <= STAT_CLAMP;
            end else begin
              m_tdata <= '0;
              m_tuser <= STAT_BEFORE;
              m_tvalid <= 1'b1;
            end
          end else begin
            s0 <= rd_s; x0 <= rd_x; y0 <= rd_y; h0 <= rd_h;
            k <= k + ADDR_W'(1);
          end
        end
        S_DIV: begin
          logic [33:0] t;
          t = {rem, 1'b0};
          if (t >= {1'b0, span}) begin
            rem <= 33'(t - {1'b0, span});
            quo <= {quo[29:0], 1'b1};
          end else begin
            rem <= t[32:0];
            quo <= {quo[29:0], 1'b0};
          end
          cnt <= (cnt == 5'd30) ? 5'd0 : cnt + 5'd1;
          m_tuser <= STAT_INTERP;
        end
        S_LERP: begin
          if (cnt[0]) begin
            logic signed [32:0] d;
            logic signed [32:0] a;
            logic signed [32:0] st;
            logic signed [32:0] dh;
            case (cnt[2:1])
              2'd0: begin a = 33'(x0); d = 33'(x1) - 33'(x0); end
              2'd1: begin a = 33'(y0); d = 33'(y1) - 33'(y0); end
              default: begin a = 33'(h0); d = 33'(h1) - 33'(h0); end
            endcase
            st = prod[63:31];
            dh = 33'(h0) - 33'(h1);
            case (cnt[2:1])
              2'd0: px <= d[32] ? 32'(a - st) : 32'(a + st);
              2'd1: py <= d[32] ? 32'(a - st) : 32'(a + st);
              default: begin
                if (dh >= WRAP_LIMIT || dh <= -WRAP_LIMIT) ph <= h1;
                else ph <= d[32] ? 32'(a - st) : 32'(a + st);
              end
            endcase
          end
          cnt <= (cnt == 5'd5) ? 5'd0 : cnt + 5'd1;
        end
        S_RLOAD: begin
          hneg <= ph[31];
          mag <= ph[31] ? 32'(-ph) : 32'(ph);
        end
        S_REDUCE: begin
          if (mag >= TWO_PI_Q24) mag <= mag - TWO_PI_Q24;
        end
        S_FOLD: begin
          logic signed [32:0] r;
          logic signed [32:0] r2;
          logic               flip;
          r = hneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          if (r > PI_Q24) r = r - TWO_PI_S;
          if (r < -PI_Q24) r = r + TWO_PI_S;
          r2 = r;
          flip = 1'b0;
          if (r > HALF_PI_Q24) begin
            r2 = r - PI_Q24; flip = 1'b1;
          end else if (r < -HALF_PI_Q24) begin
            r2 = r + PI_Q24; flip = 1'b1;
          end
          neg <= flip;
          cz <= r2[31:0];
          cx <= CORDIC_GAIN;
          cy <= '0;
          cnt <= '0;
        end
        S_CORDIC: begin
          if (!cz[31]) begin
            cx <= cx - (cy >>> cnt);
            cy <= cy + (cx >>> cnt);
            cz <= cz - atan_q24(cnt);
          end else begin
            cx <= cx + (cy >>> cnt);
            cy <= cy - (cx >>> cnt);
            cz <= cz + atan_q24(cnt);
          end
          cnt <= (cnt == 5'(CORDIC_STEPS - 1)) ? 5'd0 : cnt + 5'd1;
        end
        S_OFFS: begin
          if (cnt == 5'd1) begin
            m_tdata[31:0] <= sat32(39'(px) - 39'($signed(prod[67:30])));
          end
          if (cnt == 5'd3) begin
            m_tdata[63:32] <= sat32(39'(py) + 39'($signed(prod[67:30])));
            m_tdata[95:64] <= ph;
            m_tvalid <= 1'b1;
          end
          cnt <= (cnt == 5'd3) ? 5'd0 : cnt + 5'd1;
        end
        default: ;
      endcase
    end
  end

endmodule
